[hdl/apc_pkg.sv]
// Package for the autoranging period counter.
// Holds the status codes, register indexes, configuration and state types.
// It has no dependencies.
`default_nettype none

package apc_pkg;

   localparam int unsigned CapWidth      = 16;
   localparam int unsigned PeriodWidth   = 32;
   localparam int unsigned ThreshWidth   = 29;
   localparam int unsigned RollCfgWidth  = 9;
   localparam int unsigned RollWidth     = 10;
   localparam int unsigned CsrAddrWidth  = 2;

   // Status codes.
   localparam logic [1:0] STATUS_INVALID = 2'd0;
   localparam logic [1:0] STATUS_PENDING = 2'd1;
   localparam logic [1:0] STATUS_VALID   = 2'd2;

   // Configuration register indexes.
   localparam logic [CsrAddrWidth-1:0] CSR_RAISE_THRESHOLD = 2'd0;
   localparam logic [CsrAddrWidth-1:0] CSR_MIN_PERIOD      = 2'd1;
   localparam logic [CsrAddrWidth-1:0] CSR_LOWER_ROLLOVERS = 2'd2;
   localparam logic [CsrAddrWidth-1:0] CSR_MAX_ROLLOVERS   = 2'd3;

   // Event kinds.
   localparam logic OP_EDGE     = 1'b0;
   localparam logic OP_ROLLOVER = 1'b1;

   localparam logic [1:0] STEP_MAX = 2'd3;
   localparam logic [RollWidth-1:0] ROLL_MAX = 10'd1023;

   typedef struct packed {
      logic [ThreshWidth-1:0]  raise_threshold;
      logic [ThreshWidth-1:0]  min_period;
      logic [RollCfgWidth-1:0] lower_rollovers;
      logic [RollCfgWidth-1:0] max_rollovers;
   } cfg_type;

   typedef struct packed {
      logic [CapWidth-1:0]    previous_capture;
      logic [1:0]             valid_state;
      logic [1:0]             prescale_step;
      logic [RollWidth-1:0]   rollover_count;
      logic [PeriodWidth-1:0] instant_value;
      logic [PeriodWidth-1:0] average_value;
   } state_type;

endpackage

`default_nettype wire

[hdl/apc_csr.sv]
// Configuration registers of the autoranging period counter.
// Depends on apc_pkg for the register indexes and the configuration struct.
`default_nettype none

module apc_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [apc_pkg::CsrAddrWidth-1:0]   csr_addr,
   input  wire logic [apc_pkg::ThreshWidth-1:0]    csr_wdata,
   output apc_pkg::cfg_type                        cfg
);

   apc_pkg::cfg_type cfg_ff;
   apc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            apc_pkg::CSR_RAISE_THRESHOLD: cfg_in.raise_threshold = csr_wdata;
            apc_pkg::CSR_MIN_PERIOD:      cfg_in.min_period      = csr_wdata;
            apc_pkg::CSR_LOWER_ROLLOVERS:
               cfg_in.lower_rollovers = csr_wdata[apc_pkg::RollCfgWidth-1:0];
            apc_pkg::CSR_MAX_ROLLOVERS:
               cfg_in.max_rollovers = csr_wdata[apc_pkg::RollCfgWidth-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.raise_threshold <= 29'h010_0000;
         cfg_ff.min_period      <= 29'h005_0000;
         cfg_ff.lower_rollovers <= 9'd16;
         cfg_ff.max_rollovers   <= 9'd272;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[hdl/apc_update.sv]
// Next-state logic of the autoranging period counter for one event.
// Depends on apc_pkg for the state and configuration structs and the codes.
`default_nettype none

module apc_update (
   input  apc_pkg::state_type                  state_cur,
   input  apc_pkg::cfg_type                    cfg,
   input  wire logic                           operation,
   input  wire logic [apc_pkg::CapWidth-1:0]   capture_count,
   output apc_pkg::state_type                  state_next
);

   logic [apc_pkg::PeriodWidth-1:0] span;
   logic [apc_pkg::PeriodWidth-1:0] instant;
   logic [apc_pkg::PeriodWidth-1:0] diff;
   logic [apc_pkg::PeriodWidth-1:0] step_adj;
   logic                            raise;
   logic                            too_short;
   logic                            lower;
   logic                            too_many;

   // Edge-to-edge span, counting whole timer wraps in the upper half.
   assign span = {6'd0, state_cur.rollover_count, 16'd0}
               + {16'd0, capture_count}
               - {16'd0, state_cur.previous_capture};
   assign instant  = {span[apc_pkg::PeriodWidth-5:0], 4'd0};
   assign diff     = instant - state_cur.average_value;
   assign step_adj = {{3{diff[apc_pkg::PeriodWidth-1]}}, diff[apc_pkg::PeriodWidth-1:3]};

   assign raise     = (instant < {3'd0, cfg.raise_threshold})
                    && (state_cur.prescale_step != apc_pkg::STEP_MAX);
   assign too_short = instant < {3'd0, cfg.min_period};
   assign lower     = (state_cur.rollover_count > {1'b0, cfg.lower_rollovers})
                    && (state_cur.prescale_step != 2'd0);
   assign too_many  = state_cur.rollover_count > {1'b0, cfg.max_rollovers};

   always_comb begin
      state_next = state_cur;
      if (operation == apc_pkg::OP_EDGE) begin
         state_next.previous_capture = capture_count;
         state_next.rollover_count   = '0;
         if (state_cur.valid_state == apc_pkg::STATUS_INVALID) begin
            state_next.average_value = '0;
            state_next.valid_state   = apc_pkg::STATUS_PENDING;
         end else begin
            state_next.instant_value = instant;
            if (state_cur.average_value == '0) begin
               state_next.average_value = instant;
            end else begin
               state_next.average_value = state_cur.average_value + step_adj;
            end
            if (raise) begin
               state_next.prescale_step = state_cur.prescale_step + 2'd1;
            end
            if (raise || too_short) begin
               state_next.valid_state = apc_pkg::STATUS_INVALID;
            end else begin
               state_next.valid_state = apc_pkg::STATUS_VALID;
            end
         end
      end else begin
         if (lower) begin
            state_next.prescale_step = state_cur.prescale_step - 2'd1;
         end
         if (lower || too_many) begin
            state_next.rollover_count = '0;
            state_next.valid_state    = apc_pkg::STATUS_INVALID;
         end else if (state_cur.rollover_count != apc_pkg::ROLL_MAX) begin
            state_next.rollover_count = state_cur.rollover_count + 10'd1;
         end
      end
   end

endmodule

`default_nettype wire

[hdl/autoranging_period_counter.sv]
// Top level of the autoranging period counter.
// Depends on apc_pkg, apc_csr and apc_update.
`default_nettype none

// The block measures edge-to-edge periods of a prescaled signal against a
// free-running 16-bit timer. Each input transfer is one event: an edge capture
// (req_tuser low) carrying the timer value, or a timer rollover tick
// (req_tuser high). Every event yields exactly one output transfer showing the
// state after the event: the status (invalid, pending first edge or valid),
// the prescaler exponent (0, 4, 8 or 12), the instant period scaled by
// sixteen and a one-eighth exponential average of it. An event sits in an
// input register, then the update logic computes the new state, which is
// loaded into the state register that also drives the result port. One event
// is taken every cycle as long as results are taken; the rate is set by the
// single state update loop. Configuration registers are written through the
// csr_ port and should only change while the block is idle.

module autoranging_period_counter (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Input channel.
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   input  wire logic [15:0]                        req_tdata,  // capture_count
   input  wire logic                               req_tuser,  // operation
   // Result channel.
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [3:0] divider_exponent, [35:4] instant_period, [67:36] average_period,
   // [71:68] zero fill
   output      logic [71:0]                        rsp_tdata,
   output      logic [1:0]                         rsp_tuser,  // status
   // Configuration port.
   input  wire logic                               csr_we,
   input  wire logic [apc_pkg::CsrAddrWidth-1:0]   csr_addr,
   input  wire logic [apc_pkg::ThreshWidth-1:0]    csr_wdata
);

   apc_pkg::cfg_type   cfg;
   apc_pkg::state_type state_ff;
   apc_pkg::state_type state_in;
   apc_pkg::state_type state_next;

   logic                          in_valid_ff;
   logic                          in_op_ff;
   logic [apc_pkg::CapWidth-1:0]  in_cap_ff;
   logic                          out_valid_ff;
   logic                          advance;

   apc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   apc_update u_update (
      .state_cur     (state_ff),
      .cfg           (cfg),
      .operation     (in_op_ff),
      .capture_count (in_cap_ff),
      .state_next    (state_next)
   );

   // The held event moves on when the result slot is empty or being emptied.
   // The state register doubles as the result register, so it only changes
   // when the previous result has been taken.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign state_in   = advance ? state_next : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff.previous_capture <= '1;
         state_ff.valid_state      <= apc_pkg::STATUS_INVALID;
         state_ff.prescale_step    <= '0;
         state_ff.rollover_count   <= '0;
         state_ff.instant_value    <= '0;
         state_ff.average_value    <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         state_ff <= state_in;
      end
   end

   // Event payload needs no reset.
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff  <= req_tuser;
         in_cap_ff <= req_tdata;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = state_ff.valid_state;
   assign rsp_tdata  = {4'd0, state_ff.average_value, state_ff.instant_value,
                        state_ff.prescale_step, 2'd0};

   // The status code three is never produced.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser != 2'd3))
      else $error("status code three on result port");

   // An edge event always leaves the rollover count cleared.
   assert property (@(posedge clock) disable iff (reset)
      (advance && (in_op_ff == apc_pkg::OP_EDGE)) |=> (state_ff.rollover_count == '0))
      else $error("rollover count not cleared by edge");

   // Every event that advances produces a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("advanced event produced no result");

   // The result does not change while it waits to be taken.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(state_ff))
      else $error("state changed under a stalled result");

endmodule

`default_nettype wire
